// ----- rtl/core/ckdf_pkg.sv -----
// Shared types, constants and the CRC-32 byte step for the chunk deframer.
package ckdf_pkg;

  localparam int MAGIC_BYTES = 8;
  localparam int HIDX_W      = 6;

  localparam logic [HIDX_W-1:0] HDR_ORIG_AT = HIDX_W'(MAGIC_BYTES + 8);
  localparam logic [HIDX_W-1:0] HDR_ENC_AT  = HIDX_W'(MAGIC_BYTES + 16);
  localparam logic [HIDX_W-1:0] HDR_CRC_AT  = HIDX_W'(MAGIC_BYTES + 24);
  localparam logic [HIDX_W-1:0] HDR_LAST    = HIDX_W'(MAGIC_BYTES + 27);
  localparam logic [HIDX_W-1:0] MAGIC_END   = HIDX_W'(MAGIC_BYTES);

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_EOS  = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_EOF  = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_SHORT_HDR     = 3'd0,
    ERR_BAD_MAGIC     = 3'd1,
    ERR_BAD_ORIG      = 3'd2,
    ERR_BAD_ENC       = 3'd3,
    ERR_SHORT_PAYLOAD = 3'd4,
    ERR_CHECKSUM      = 3'd5
  } err_t;

  // Everything one input beat produces: an optional payload byte and an
  // optional closing result (done, end of stream or error).
  typedef struct packed {
    logic        has_byte;
    logic [7:0]  byte_val;
    logic        has_tail;
    kind_t       tail_kind;
    logic [30:0] orig;
    logic [30:0] enc;
    err_t        code;
  } res_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/ckdf_front.sv -----
// Front end: header parse, size checks, running CRC and result classification.
module ckdf_front import ckdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic        req_type,
  input  logic [7:0]  data_byte,
  input  logic [63:0] magic_word,
  output logic        push,
  output res_t        push_data
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_HALTED  = 3'b100
  } phase_t;

  phase_t            phase, phase_next;
  logic [HIDX_W-1:0] hidx, hidx_next;
  logic              magic_ok, magic_ok_next;
  logic [30:0]       orig_lo, orig_lo_next;
  logic              orig_big, orig_big_next;
  logic [30:0]       enc_lo, enc_lo_next;
  logic              enc_big, enc_big_next;
  logic [31:0]       exp_crc, exp_crc_next;
  logic [31:0]       run_crc, run_crc_next;
  logic [30:0]       left, left_next;

  logic [31:0]       crc_upd;
  logic [31:0]       exp_now;
  logic [7:0]        magic_sel;
  logic [2:0]        off;

  assign crc_upd   = crc_byte(run_crc, data_byte);
  assign exp_now   = {data_byte, exp_crc[23:0]};
  assign magic_sel = magic_word[{hidx[2:0], 3'b000} +: 8];

  always_comb begin
    phase_next    = phase;
    hidx_next     = hidx;
    magic_ok_next = magic_ok;
    orig_lo_next  = orig_lo;
    orig_big_next = orig_big;
    enc_lo_next   = enc_lo;
    enc_big_next  = enc_big;
    exp_crc_next  = exp_crc;
    run_crc_next  = run_crc;
    left_next     = left;
    push          = 1'b0;
    push_data     = '0;
    off           = '0;

    if (fire) begin
      unique case (phase)
        PH_HEADER: begin
          if (req_type == REQ_EOS) begin
            push               = 1'b1;
            push_data.has_tail = 1'b1;
            push_data.tail_kind = (hidx == '0) ? KIND_EOF : KIND_ERR;
            push_data.code     = ERR_SHORT_HDR;
            phase_next         = PH_HALTED;
          end else begin
            hidx_next = hidx + 1'b1;
            if (hidx < MAGIC_END) begin
              // first magic byte restarts the match flag
              magic_ok_next = ((hidx == '0) ? 1'b1 : magic_ok) && (data_byte == magic_sel);
            end else if (hidx >= HDR_ORIG_AT && hidx < HDR_ENC_AT) begin
              off = 3'(hidx - HDR_ORIG_AT);
              if (off < 3'd3) begin
                orig_lo_next[{off[1:0], 3'b000} +: 8] = data_byte;
              end else if (off == 3'd3) begin
                orig_lo_next[30:24] = data_byte[6:0];
                orig_big_next       = data_byte[7];
              end else begin
                orig_big_next = orig_big | (data_byte != 8'd0);
              end
            end else if (hidx >= HDR_ENC_AT && hidx < HDR_CRC_AT) begin
              off = 3'(hidx - HDR_ENC_AT);
              if (off < 3'd3) begin
                enc_lo_next[{off[1:0], 3'b000} +: 8] = data_byte;
              end else if (off == 3'd3) begin
                enc_lo_next[30:24] = data_byte[6:0];
                enc_big_next       = data_byte[7];
              end else begin
                enc_big_next = enc_big | (data_byte != 8'd0);
              end
            end else if (hidx >= HDR_CRC_AT) begin
              off = 3'(hidx - HDR_CRC_AT);
              exp_crc_next[{off[1:0], 3'b000} +: 8] = data_byte;
            end

            if (hidx == HDR_LAST) begin
              // header complete: checks in fixed order
              priority if (!magic_ok) begin
                push = 1'b1; push_data.has_tail = 1'b1;
                push_data.tail_kind = KIND_ERR; push_data.code = ERR_BAD_MAGIC;
                phase_next = PH_HALTED;
              end else if (orig_big) begin
                push = 1'b1; push_data.has_tail = 1'b1;
                push_data.tail_kind = KIND_ERR; push_data.code = ERR_BAD_ORIG;
                phase_next = PH_HALTED;
              end else if (enc_big) begin
                push = 1'b1; push_data.has_tail = 1'b1;
                push_data.tail_kind = KIND_ERR; push_data.code = ERR_BAD_ENC;
                phase_next = PH_HALTED;
              end else if (enc_lo == '0) begin
                // empty payload: compare CRC of nothing right away
                push = 1'b1; push_data.has_tail = 1'b1;
                if (~run_crc == exp_now) begin
                  push_data.tail_kind = KIND_DONE;
                  push_data.orig      = orig_lo;
                  push_data.enc       = enc_lo;
                  phase_next          = PH_HEADER;
                  hidx_next           = '0;
                  run_crc_next        = CRC_INIT;
                end else begin
                  push_data.tail_kind = KIND_ERR;
                  push_data.code      = ERR_CHECKSUM;
                  phase_next          = PH_HALTED;
                end
              end else begin
                left_next  = enc_lo;
                phase_next = PH_PAYLOAD;
              end
            end
          end
        end

        PH_PAYLOAD: begin
          push = 1'b1;
          if (req_type == REQ_EOS) begin
            push_data.has_tail  = 1'b1;
            push_data.tail_kind = KIND_ERR;
            push_data.code      = ERR_SHORT_PAYLOAD;
            phase_next          = PH_HALTED;
          end else begin
            push_data.has_byte = 1'b1;
            push_data.byte_val = data_byte;
            run_crc_next       = crc_upd;
            left_next          = left - 1'b1;
            if (left == 31'd1) begin
              push_data.has_tail = 1'b1;
              if (~crc_upd == exp_crc) begin
                push_data.tail_kind = KIND_DONE;
                push_data.orig      = orig_lo;
                push_data.enc       = enc_lo;
                phase_next          = PH_HEADER;
                hidx_next           = '0;
                run_crc_next        = CRC_INIT;
              end else begin
                push_data.tail_kind = KIND_ERR;
                push_data.code      = ERR_CHECKSUM;
                phase_next          = PH_HALTED;
              end
            end
          end
        end

        PH_HALTED: begin
          phase_next = PH_HALTED;
        end

        default: begin
          phase_next = PH_HALTED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      hidx     <= '0;
      magic_ok <= 1'b1;
      orig_big <= 1'b0;
      enc_big  <= 1'b0;
      run_crc  <= CRC_INIT;
      left     <= '0;
    end else begin
      phase    <= phase_next;
      hidx     <= hidx_next;
      magic_ok <= magic_ok_next;
      orig_big <= orig_big_next;
      enc_big  <= enc_big_next;
      run_crc  <= run_crc_next;
      left     <= left_next;
    end
  end

  // header fields are fully rewritten in every header
  always_ff @(posedge clk) begin
    orig_lo <= orig_lo_next;
    enc_lo  <= enc_lo_next;
    exp_crc <= exp_crc_next;
  end

endmodule

// ----- rtl/core/ckdf_queue.sv -----
// Small result queue between the front and back ends.
module ckdf_queue import ckdf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output res_t pop_data
);

  res_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/ckdf_back.sv -----
// Back end: output register that splits a queue entry into its result beats.
module ckdf_back import ckdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  res_t        q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  payload_byte,
  output logic [30:0] orig_size,
  output logic [30:0] enc_size,
  output logic [2:0]  error_code,
  output logic        last
);

  res_t cur;
  logic vld;
  logic on_tail;
  logic take;
  logic done_cur;
  logic to_tail;

  assign take     = vld && out_ready;
  assign done_cur = take && (on_tail || !cur.has_tail);
  assign to_tail  = take && !on_tail && cur.has_tail;
  assign q_pop    = !q_empty && (!vld || done_cur);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= 1'b0;
      on_tail <= 1'b0;
    end else if (q_pop) begin
      vld     <= 1'b1;
      on_tail <= !q_data.has_byte;
    end else if (done_cur) begin
      vld <= 1'b0;
    end else if (to_tail) begin
      on_tail <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  assign out_valid    = vld;
  assign kind         = on_tail ? cur.tail_kind : KIND_BYTE;
  assign payload_byte = on_tail ? 8'd0 : cur.byte_val;
  assign orig_size    = on_tail ? cur.orig : 31'd0;
  assign enc_size     = on_tail ? cur.enc : 31'd0;
  assign error_code   = on_tail ? cur.code : ERR_SHORT_HDR;
  assign last         = on_tail || !cur.has_tail;

endmodule

// ----- rtl/core/chunk_deframer_crc32_check.sv -----
// Top level of the chunk deframer with CRC-32 payload check.
//
// Input channel (in_valid/in_ready): one beat per stream byte (req_type 0,
// data_byte) or an end-of-stream mark (req_type 1). Output channel
// (out_valid/out_ready): payload bytes as they arrive, then per chunk a
// done beat with both sizes or an error beat; end of stream on a header
// boundary gives an EOF beat. last marks the final beat from one input beat.
// Config channel (cfg_valid/cfg_ready, magic_word): sets the expected magic,
// first byte in the low bits; always ready, used from the next beat on.
//
// Throughput: one input beat per cycle while the queue is not full. The front
// end parses the header and runs the byte-wide CRC on each beat; a 4-entry
// queue feeds the output register. A beat that ends a payload yields two
// output beats: its payload byte, then the done or error beat.
// A stalled receiver fills the queue and then drops in_ready; the front end
// keeps its state. After an error or EOF, input beats are still taken but
// give no output until reset. Reset (rst, synchronous) clears the magic to
// zero, empties the queue and returns to the start of a header.
module chunk_deframer_crc32_check import ckdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  payload_byte,
  output logic [30:0] orig_size,
  output logic [30:0] enc_size,
  output logic [2:0]  error_code,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] magic_word
);

  logic [63:0] magic_reg;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  logic        push;
  res_t        push_data;
  res_t        q_data;

  assign cfg_ready = 1'b1;
  // queue space is the only backpressure on the input side
  assign in_ready  = !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_reg <= '0;
    end else if (cfg_valid) begin
      magic_reg <= magic_word;
    end
  end

  ckdf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .fire      (in_valid && in_ready),
    .req_type  (req_type),
    .data_byte (data_byte),
    .magic_word(magic_reg),
    .push      (push),
    .push_data (push_data)
  );

  ckdf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_data (q_data)
  );

  ckdf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .payload_byte(payload_byte),
    .orig_size   (orig_size),
    .enc_size    (enc_size),
    .error_code  (error_code),
    .last        (last)
  );

endmodule
